FILE: hw/rtl/fmvbd_pkg.sv
`default_nettype none

package fmvbd_pkg;

    localparam int unsigned PosWidth = 13;

    localparam logic [PosWidth-1:0] DumpSize    = 13'd4104;
    localparam logic [PosWidth-1:0] PosStart    = 13'd0;
    localparam logic [PosWidth-1:0] PosVendor   = 13'd1;
    localparam logic [PosWidth-1:0] PosFormat   = 13'd3;
    localparam logic [PosWidth-1:0] PosData     = 13'd6;
    localparam logic [PosWidth-1:0] PosChecksum = 13'd4102;
    localparam logic [PosWidth-1:0] PosEnd      = 13'd4103;

    localparam logic [7:0] ByteStart  = 8'hF0;
    localparam logic [7:0] ByteVendor = 8'h43;
    localparam logic [7:0] ByteFormat = 8'h09;
    localparam logic [7:0] ByteEnd    = 8'hF7;

    typedef enum logic [2:0] {
        ERR_OK       = 3'd0,
        ERR_SIZE     = 3'd1,
        ERR_START    = 3'd2,
        ERR_VENDOR   = 3'd3,
        ERR_END      = 3'd4,
        ERR_FORMAT   = 3'd5,
        ERR_CHECKSUM = 3'd6
    } t_err;

    typedef struct packed {
        logic [7:0] dump_byte;
        logic       is_last;
    } t_dump_in;

    typedef struct packed {
        logic       has_voice_byte;
        logic [7:0] voice_byte;
        logic [6:0] voice_byte_index;
        logic       is_verdict;
        logic       dump_ok;
        logic [2:0] error_code;
    } t_dump_out;

endpackage

`default_nettype wire

FILE: hw/rtl/fmvbd_check.sv
`default_nettype none

module fmvbd_check (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_step,
    input  wire fmvbd_pkg::t_dump_in i_item,
    input  wire logic [4:0]         i_voice_select,
    output fmvbd_pkg::t_dump_out    o_result,
    output logic                    o_has_result
);
    import fmvbd_pkg::*;

    logic [PosWidth-1:0] r_pos, n_pos;
    logic [6:0]          r_acc, n_acc;
    logic [7:0]          r_stored, n_stored;
    logic                r_start_bad, n_start_bad;
    logic                r_vendor_bad, n_vendor_bad;
    logic                r_format_bad, n_format_bad;

    logic                in_range;
    logic                in_data;
    logic [PosWidth-1:0] data_off;
    logic                in_window;
    logic [6:0]          acc_upd;
    t_err                code;

    always_comb begin
        in_range  = r_pos < DumpSize;
        in_data   = (r_pos >= PosData) && (r_pos < PosChecksum);
        data_off  = r_pos - PosData;
        // The voice window is 128 bytes, so the voice number is the upper offset bits.
        in_window = in_data && (data_off[11:7] == i_voice_select);
        acc_upd   = r_acc - i_item.dump_byte[6:0];
    end

    always_comb begin
        priority if (r_pos != PosEnd) begin
            code = ERR_SIZE;
        end else if (r_start_bad) begin
            code = ERR_START;
        end else if (r_vendor_bad) begin
            code = ERR_VENDOR;
        end else if (i_item.dump_byte != ByteEnd) begin
            code = ERR_END;
        end else if (r_format_bad) begin
            code = ERR_FORMAT;
        end else if (r_stored != {1'b0, r_acc}) begin
            code = ERR_CHECKSUM;
        end else begin
            code = ERR_OK;
        end
    end

    always_comb begin
        o_result.has_voice_byte   = in_window;
        o_result.voice_byte       = in_window ? i_item.dump_byte : 8'd0;
        o_result.voice_byte_index = in_window ? data_off[6:0] : 7'd0;
        o_result.is_verdict       = i_item.is_last;
        o_result.dump_ok          = i_item.is_last && (code == ERR_OK);
        o_result.error_code       = i_item.is_last ? code : ERR_OK;
        o_has_result              = in_window || i_item.is_last;
    end

    always_comb begin
        n_pos        = r_pos;
        n_acc        = r_acc;
        n_stored     = r_stored;
        n_start_bad  = r_start_bad;
        n_vendor_bad = r_vendor_bad;
        n_format_bad = r_format_bad;
        if (i_step) begin
            if (i_item.is_last) begin
                n_pos        = '0;
                n_acc        = '0;
                n_stored     = '0;
                n_start_bad  = 1'b0;
                n_vendor_bad = 1'b0;
                n_format_bad = 1'b0;
            end else if (in_range) begin
                n_pos = r_pos + 13'd1;
                if (r_pos == PosStart) begin
                    n_start_bad = (i_item.dump_byte != ByteStart);
                end
                if (r_pos == PosVendor) begin
                    n_vendor_bad = (i_item.dump_byte != ByteVendor);
                end
                if (r_pos == PosFormat) begin
                    n_format_bad = (i_item.dump_byte != ByteFormat);
                end
                if (r_pos == PosChecksum) begin
                    n_stored = i_item.dump_byte;
                end
                if (in_data) begin
                    n_acc = acc_upd;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos        <= '0;
            r_acc        <= '0;
            r_stored     <= '0;
            r_start_bad  <= 1'b0;
            r_vendor_bad <= 1'b0;
            r_format_bad <= 1'b0;
        end else begin
            r_pos        <= n_pos;
            r_acc        <= n_acc;
            r_stored     <= n_stored;
            r_start_bad  <= n_start_bad;
            r_vendor_bad <= n_vendor_bad;
            r_format_bad <= n_format_bad;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/fm_voice_bulk_dump_checker.sv
// A word accepted at the input is held in the input register; its result word, if it makes
// one, is then registered in the result register, where it waits to be taken.
// Throughput: one word per cycle; the input register and the result register
// advance together, and only a result word waiting at the output stalls input.
// Reset (synchronous, active low) clears the stream state, both valid flags
// and the voice selection to voice 0.
`default_nettype none

module fm_voice_bulk_dump_checker (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_cfg_valid,
    output logic                     o_cfg_ready,
    input  wire logic [4:0]          i_cfg_data,
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire fmvbd_pkg::t_dump_in i_in_data,
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output fmvbd_pkg::t_dump_out     o_out_data
);
    import fmvbd_pkg::*;

    logic [4:0] r_voice_sel;
    logic       r_in_valid;
    t_dump_in   r_in;
    logic       r_out_valid;
    t_dump_out  r_out;

    t_dump_out  result;
    logic       has_result;
    logic       out_free;
    logic       step;

    assign o_cfg_ready = 1'b1;
    assign out_free    = !r_out_valid || i_out_ready;
    // A word that makes no result leaves the input register even when the output is full.
    assign step        = r_in_valid && (!has_result || out_free);
    assign o_in_ready  = !r_in_valid || step;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    fmvbd_check u_check (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_step         (step),
        .i_item         (r_in),
        .i_voice_select (r_voice_sel),
        .o_result       (result),
        .o_has_result   (has_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_voice_sel    <= '0;
            r_in_valid     <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_voice_sel    <= i_cfg_data;
            end
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (step && has_result) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_data;
        end
        if (step && has_result) begin
            r_out <= result;
        end
    end

endmodule

`default_nettype wire

FILE: test/fm_voice_bulk_dump_checker_tb.sv
`default_nettype none

module fm_voice_bulk_dump_checker_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import fmvbd_pkg::*;

    // Bits of the damage mask applied to a generated dump.
    localparam int FlawStart       = 0;
    localparam int FlawVendor      = 1;
    localparam int FlawFormat      = 2;
    localparam int FlawEnd         = 3;
    localparam int FlawChecksum    = 4;
    localparam int FlawChecksumTop = 5;
    localparam int NumFlaws        = 6;

    localparam int NoSwitch     = -1;
    localparam int VoiceLen     = 128;
    localparam int HoldAtResult = 40;
    localparam int HoldCycles   = 400;
    localparam int DrainCycles  = 4;
    localparam int EndGuard     = 20000;

    class dump_scoreboard;
        logic [4:0]  voice_sel;
        logic [12:0] position;
        logic [6:0]  neg_sum;
        logic [7:0]  checksum_byte;
        logic        start_bad;
        logic        vendor_bad;
        logic        format_bad;
        t_dump_out   expected_q[$];
        int          n_errors;

        function new();
            voice_sel = '0;
            n_errors  = 0;
            clear_stream();
        endfunction

        function void clear_stream();
            position      = '0;
            neg_sum       = '0;
            checksum_byte = '0;
            start_bad     = 1'b0;
            vendor_bad    = 1'b0;
            format_bad    = 1'b0;
        endfunction

        function void set_voice(logic [4:0] v);
            voice_sel = v;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void note_input(t_dump_in w);
            t_dump_out   exp_w;
            logic [12:0] pos;
            t_err        code;
            int          n;
            int          lo;
            exp_w = '0;
            pos   = position;
            if (pos < DumpSize) begin
                if (pos == PosStart) begin
                    start_bad = (w.dump_byte != ByteStart);
                end else if (pos == PosVendor) begin
                    vendor_bad = (w.dump_byte != ByteVendor);
                end else if (pos == PosFormat) begin
                    format_bad = (w.dump_byte != ByteFormat);
                end else if (pos == PosChecksum) begin
                    checksum_byte = w.dump_byte;
                end
                if (pos >= PosData && pos < PosChecksum) begin
                    n  = int'(pos) - int'(PosData);
                    lo = int'(voice_sel) * VoiceLen;
                    neg_sum = neg_sum - w.dump_byte[6:0];
                    if (n >= lo && n < lo + VoiceLen) begin
                        exp_w.has_voice_byte   = 1'b1;
                        exp_w.voice_byte       = w.dump_byte;
                        exp_w.voice_byte_index = 7'(n - lo);
                    end
                end
                position = pos + 13'd1;
            end
            if (w.is_last) begin
                if (pos != PosEnd)
                    code = ERR_SIZE;
                else if (start_bad)
                    code = ERR_START;
                else if (vendor_bad)
                    code = ERR_VENDOR;
                else if (w.dump_byte != ByteEnd)
                    code = ERR_END;
                else if (format_bad)
                    code = ERR_FORMAT;
                else if (checksum_byte != {1'b0, neg_sum})
                    code = ERR_CHECKSUM;
                else
                    code = ERR_OK;
                exp_w.is_verdict = 1'b1;
                exp_w.dump_ok    = (code == ERR_OK);
                exp_w.error_code = code;
                clear_stream();
            end
            if (exp_w.has_voice_byte || exp_w.is_verdict)
                expected_q.push_back(exp_w);
        endfunction

        function void check_result(t_dump_out got);
            t_dump_out exp_w;
            if (expected_q.size() == 0) begin
                $error("result word with no expectation waiting: %h", got);
                n_errors++;
                return;
            end
            exp_w = expected_q.pop_front();
            if (got.has_voice_byte !== exp_w.has_voice_byte) begin
                $error("has_voice_byte: expected %0d, got %0d",
                       exp_w.has_voice_byte, got.has_voice_byte);
                n_errors++;
            end
            if (got.voice_byte !== exp_w.voice_byte) begin
                $error("voice_byte: expected %02h, got %02h", exp_w.voice_byte, got.voice_byte);
                n_errors++;
            end
            if (got.voice_byte_index !== exp_w.voice_byte_index) begin
                $error("voice_byte_index: expected %0d, got %0d",
                       exp_w.voice_byte_index, got.voice_byte_index);
                n_errors++;
            end
            if (got.is_verdict !== exp_w.is_verdict) begin
                $error("is_verdict: expected %0d, got %0d", exp_w.is_verdict, got.is_verdict);
                n_errors++;
            end
            if (got.dump_ok !== exp_w.dump_ok) begin
                $error("dump_ok: expected %0d, got %0d", exp_w.dump_ok, got.dump_ok);
                n_errors++;
            end
            if (got.error_code !== exp_w.error_code) begin
                $error("error_code: expected %0d, got %0d", exp_w.error_code, got.error_code);
                n_errors++;
            end
        endfunction
    endclass

    logic       clk = 1'b0;
    logic       rst_n;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [4:0] cfg_data;
    logic       in_valid;
    logic       in_ready;
    t_dump_in   in_data;
    logic       out_valid;
    logic       out_ready;
    t_dump_out  out_data;

    logic tx_idle = 1'b0;
    logic rx_idle = 1'b0;
    int   n_results = 0;

    dump_scoreboard sb = new();

    fm_voice_bulk_dump_checker dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_valid(cfg_valid),
        .o_cfg_ready(cfg_ready),
        .i_cfg_data (cfg_data),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in_data  (in_data),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_data (out_data)
    );

    always #5 clk = ~clk;

    task automatic pick_pace();
        tx_idle = ($urandom_range(0, 3) != 0);
        rx_idle = ($urandom_range(0, 3) != 0);
    endtask

    task automatic send_word(input logic [7:0] b, input logic last);
        int gap;
        gap = tx_idle ? $urandom_range(0, 5) : 0;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= '{dump_byte: b, is_last: last};
        do @(posedge clk); while (!in_ready);
        sb.note_input('{dump_byte: b, is_last: last});
    endtask

    // Voice selection may only change once the block has nothing in flight.
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (DrainCycles) @(posedge clk);
    endtask

    task automatic write_voice(input logic [4:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.set_voice(v);
    endtask

    // Builds a dump with a correct layout and checksum, then applies the damage
    // mask. Lengths other than the full size give short or overlong files.
    task automatic send_dump(input int n_bytes, input logic [NumFlaws-1:0] flaws,
                             input int switch_at, input logic [4:0] switch_voice);
        logic [7:0] b;
        logic [6:0] running;
        running = '0;
        for (int p = 0; p < n_bytes; p++) begin
            if (p == switch_at) begin
                wait_idle();
                write_voice(switch_voice);
            end
            b = 8'($urandom);
            if (p == int'(PosStart)) begin
                b = ByteStart;
                if (flaws[FlawStart]) b ^= 8'(1 << $urandom_range(0, 7));
            end else if (p == int'(PosVendor)) begin
                b = ByteVendor;
                if (flaws[FlawVendor]) b ^= 8'(1 << $urandom_range(0, 7));
            end else if (p == int'(PosFormat)) begin
                b = ByteFormat;
                if (flaws[FlawFormat]) b ^= 8'(1 << $urandom_range(0, 7));
            end else if (p >= int'(PosData) && p < int'(PosChecksum)) begin
                running = running - b[6:0];
            end else if (p == int'(PosChecksum)) begin
                b = {1'b0, running};
                if (flaws[FlawChecksumTop]) b[7] = 1'b1;
                if (flaws[FlawChecksum]) b[0] = ~b[0];
            end else if (p == int'(PosEnd)) begin
                b = ByteEnd;
                if (flaws[FlawEnd]) b ^= 8'(1 << $urandom_range(0, 7));
            end
            send_word(b, p == n_bytes - 1);
        end
    endtask

    initial begin
        int timeout_ns;
        timeout_ns = 1_000_000;
        #(timeout_ns);
        $display("CHECKS FAILED");
        $finish;
    end

    // Receiver: checks each accepted word and draws a pause after it. Once,
    // it holds off long enough for the block to back up into its input.
    initial begin
        int stall_left;
        stall_left = 0;
        out_ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            @(posedge clk);
            if (out_valid && out_ready) begin
                sb.check_result(out_data);
                n_results++;
                if (n_results == HoldAtResult)
                    stall_left = HoldCycles;
                else
                    stall_left = rx_idle ? $urandom_range(0, 5) : 0;
            end
            if (stall_left > 0) begin
                out_ready <= 1'b0;
                stall_left--;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    initial begin
        logic [7:0] hdr_short [0:7];
        logic [7:0] all_ones [0:6];
        int n_noise;
        int guard;
        hdr_short = '{8'hF0, 8'h43, 8'h00, 8'h09, 8'h20, 8'h00, 8'h7F, 8'h80};
        all_ones  = '{default: 8'hFF};
        rst_n     <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_data  <= '0;
        in_valid  <= 1'b0;
        in_data   <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: one-byte files, and short files whose last byte lands in
        // the window of voice 0 so that voice byte and verdict share a word.
        send_word(ByteStart, 1'b1);
        send_word(8'h00, 1'b1);
        send_word(8'hFF, 1'b1);
        foreach (hdr_short[i]) send_word(hdr_short[i], i == 7);
        foreach (all_ones[i]) send_word(all_ones[i], i == 6);
        wait_idle();

        // The whole window of voice 0 and a little past it.
        write_voice(5'd0);
        pick_pace();
        send_dump(136, '0, NoSwitch, '0);
        wait_idle();

        // Selection moves from voice 0 to voice 1 partway through the data.
        write_voice(5'd0);
        pick_pace();
        send_dump(180, '0, 90, 5'd1);
        wait_idle();

        // Short files: mostly a proper header with random length, the rest
        // plain noise.
        n_noise = 0;
        while (n_noise < 200) begin
            if ($urandom_range(0, 3) == 0) begin
                wait_idle();
                write_voice($urandom_range(0, 2) == 0 ? 5'($urandom_range(0, 31))
                                                       : 5'($urandom_range(0, 1)));
            end
            pick_pace();
            if ($urandom_range(0, 9) < 7) begin
                guard = $urandom_range(1, 100);
                send_dump(guard, NumFlaws'($urandom_range(0, 3) == 0 ? $urandom : 0),
                          NoSwitch, '0);
            end else begin
                guard = $urandom_range(1, 20);
                for (int i = 0; i < guard; i++)
                    send_word(8'($urandom), i == guard - 1);
            end
            n_noise += guard;
        end

        in_valid <= 1'b0;
        guard = 0;
        while (sb.pending() != 0 && guard < EndGuard) begin
            @(posedge clk);
            guard++;
        end
        repeat (DrainCycles) @(posedge clk);
        if (sb.pending() != 0) begin
            $error("%0d expected words never arrived", sb.pending());
            sb.n_errors++;
        end
        if (sb.n_errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire
